@@ rtl/core/grtc_pkg.sv @@
// shared types, widths and fixed coefficients of the gyro rate compensation
`default_nettype none
package grtc_pkg;

  // adc and fixed-point widths
  localparam int ADC_BITS   = 10;
  localparam int CNT_FRAC   = 12;
  localparam int DIV_SHIFT  = ADC_BITS - 1 + CNT_FRAC;
  localparam int Q_W        = ADC_BITS + DIV_SHIFT;
  localparam int DIFF_W     = Q_W + 1;
  localparam int VPC_W      = 24;
  localparam int PROD_W     = DIFF_W + VPC_W + 1;
  localparam int VOLT_SHIFT = 16;
  localparam int SH_W       = PROD_W - VOLT_SHIFT;
  localparam int DV_W       = 32;
  localparam int VOLT_FRAC  = 20;
  localparam int COMP_W     = 41;
  localparam int SCALE_W    = 43;
  localparam int MAG_W      = 40;
  localparam int N_W        = 62;
  localparam int QF_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NULL_ROLL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NULL_PITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NULL_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_NULL_ROLL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_NULL_PITCH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_NULL_YAW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_COUNT = 3'd6;

  // register reset values
  localparam logic [ADC_BITS-1:0] RST_RATE_NULL_ROLL  = 10'd480;
  localparam logic [ADC_BITS-1:0] RST_RATE_NULL_PITCH = 10'd512;
  localparam logic [ADC_BITS-1:0] RST_RATE_NULL_YAW   = 10'd480;
  localparam logic [ADC_BITS-1:0] RST_TEMP_NULL       = 10'd526;
  localparam logic [VPC_W-1:0]    RST_VOLTS_PER_COUNT = 24'd81920;

  // axis codes
  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  // polynomial and unit coefficients, Q.20 unless noted
  localparam logic signed [14:0] NULL_K1  = 15'sd9018;
  localparam logic [15:0]        NULL_K2  = 16'd37717;
  localparam logic [23:0]        SCALE_K0 = 24'd13363053;
  localparam logic signed [21:0] SCALE_K1 = 22'sd1321794;
  localparam logic [19:0]        SCALE_K2 = 20'd705482;
  // mV per deg/s to rad/s in Q16.16
  localparam logic [20:0]        RAD_K    = 21'd1143819;

  typedef struct packed {
    logic [1:0]          axis;
    logic [ADC_BITS-1:0] rate_count;
    logic [ADC_BITS-1:0] ref_count;
    logic [ADC_BITS-1:0] temp_count;
  } sample_t;

  typedef struct packed {
    logic [1:0]         axis_out;
    logic signed [31:0] rate_rad_per_s;
    logic               invalid;
  } result_t;

  // control that travels beside the data path
  typedef struct packed {
    logic       vld;
    logic [1:0] axis;
    logic       inv;
    logic       neg;
    logic       ovf;
  } tag_t;

endpackage
`default_nettype wire

@@ rtl/core/grtc_udiv.sv @@
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none
module grtc_udiv #(
  parameter int LW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_init,
  input  logic [LW-1:0] dividend,
  input  logic [DW-1:0] den,
  output logic [LW-1:0] quot
);

  logic [DW-1:0] rem [1:LW];
  logic [LW-1:0] dq  [1:LW];
  logic [DW-1:0] dv  [1:LW-1];

  for (genvar i = 0; i < LW; i++) begin : g_stage
    logic [DW-1:0] rem_c;
    logic [LW-1:0] dq_c;
    logic [DW-1:0] dv_c;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_c = rem_init;
      assign dq_c  = dividend;
      assign dv_c  = den;
    end else begin : g_next
      assign rem_c = rem[i];
      assign dq_c  = dq[i];
      assign dv_c  = dv[i];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_c, dq_c[LW-1]};
    assign diff  = trial - {1'b0, dv_c};
    assign ge    = trial >= {1'b0, dv_c};

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      dq[i+1]  <= {dq_c[LW-2:0], ge};
    end

    if (i < LW - 1) begin : g_den
      always_ff @(posedge clk) begin
        dv[i+1] <= dv_c;
      end
    end
  end

  assign quot = dq[LW];

endmodule
`default_nettype wire

@@ rtl/core/grtc_poly.sv @@
// three stage temperature polynomials: null offset and scale factor
`default_nettype none
module grtc_poly (
  input  logic                                  clk,
  input  logic signed [grtc_pkg::DV_W-1:0]      d_rate,
  input  logic signed [grtc_pkg::DV_W-1:0]      d_temp,
  output logic signed [grtc_pkg::COMP_W-1:0]    comp,
  output logic [grtc_pkg::SCALE_W-1:0]          scale
);
  import grtc_pkg::*;

  localparam int D2_W = 42;

  logic signed [63:0]     p1_sq;
  logic signed [46:0]     p1_t1;
  logic signed [53:0]     p1_s1;
  logic signed [DV_W-1:0] p1_rate;

  logic [D2_W-1:0]        d2;
  logic [37:0]            p2_k2_hi;
  logic [35:0]            p2_k2_lo;
  logic [41:0]            p2_sk2_hi;
  logic [39:0]            p2_sk2_lo;
  logic signed [26:0]     p2_t1;
  logic signed [33:0]     p2_s1;
  logic signed [DV_W-1:0] p2_rate;

  logic [38:0]               t2;
  logic [SCALE_W-1:0]        s2;
  logic signed [COMP_W-1:0]  comp_c;
  logic signed [SCALE_W:0]   scale_c;

  // square and linear terms
  always_ff @(posedge clk) begin
    p1_sq   <= d_temp * d_temp;
    p1_t1   <= NULL_K1 * d_temp;
    p1_s1   <= SCALE_K1 * d_temp;
    p1_rate <= d_rate;
  end

  // square back to Q.20, split so each quadratic product stays narrow
  assign d2 = p1_sq[D2_W+VOLT_FRAC-1:VOLT_FRAC];

  always_ff @(posedge clk) begin
    p2_k2_hi  <= NULL_K2 * d2[D2_W-1:VOLT_FRAC];
    p2_k2_lo  <= NULL_K2 * d2[VOLT_FRAC-1:0];
    p2_sk2_hi <= SCALE_K2 * d2[D2_W-1:VOLT_FRAC];
    p2_sk2_lo <= SCALE_K2 * d2[VOLT_FRAC-1:0];
    p2_t1     <= p1_t1[46:VOLT_FRAC];
    p2_s1     <= p1_s1[53:VOLT_FRAC];
    p2_rate   <= p1_rate;
  end

  // high half is a multiple of 2^20, so the floor only hits the low half
  assign t2 = 39'(p2_k2_hi) + 39'(p2_k2_lo[35:VOLT_FRAC]);
  assign s2 = SCALE_W'(p2_sk2_hi) + SCALE_W'(p2_sk2_lo[39:VOLT_FRAC]);

  assign comp_c  = COMP_W'(p2_rate) - COMP_W'(p2_t1) - $signed({2'b00, t2});
  assign scale_c = $signed((SCALE_W+1)'(SCALE_K0)) + (SCALE_W+1)'(p2_s1)
                 + $signed({1'b0, s2});

  // offset-corrected rate and scale factor, scale held at one lsb or more
  always_ff @(posedge clk) begin
    comp <= comp_c;
    if (scale_c < $signed((SCALE_W+1)'(1))) begin
      scale <= SCALE_W'(1);
    end else begin
      scale <= scale_c[SCALE_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gyro_rate_temp_compensation.sv @@
// top level of the temperature compensated gyro rate pipeline
//
// One gyro axis sample is taken at each clock edge where start is high and
// busy is low; busy is only high during reset, so a sample may come every
// cycle. A sample word carries axis, rate, reference and temperature counts.
// Each sample yields one result word: axis_out, rate_rad_per_s (signed Q16.16
// rad/s, saturated) and invalid. result_valid is high for exactly one cycle
// per result; results leave in sample order and the receiver cannot hold
// them off. Throughput is one sample per cycle. Pipelined dividers, one
// stage per quotient bit, do the reference rescale of the rate and
// temperature counts (31 stages each, side by side) and the final rate
// over scale factor (32 stages).
// Configuration is a write port (cfg_we, cfg_index, cfg_data) taken at
// any edge with cfg_we high and rst low; write it only while no sample is
// in flight. Indexes past the last register are ignored.
// Synchronous reset loads the default nulls and volts per count and drops
// every sample still in the pipeline.
`default_nettype none
module gyro_rate_temp_compensation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  grtc_pkg::sample_t                 sample,
  output logic                              result_valid,
  output grtc_pkg::result_t                 result,
  input  logic                              cfg_we,
  input  logic [grtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [grtc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import grtc_pkg::*;

  localparam int POLY_LAT = 3;
  localparam int LATENCY  = 1 + Q_W + 3 + POLY_LAT + 2 + QF_W + 1;

  localparam logic signed [SH_W-1:0] V_HI = SH_W'(64'sd2147483647);
  localparam logic signed [SH_W-1:0] V_LO = -V_HI;

  // configuration registers
  logic [ADC_BITS-1:0] rate_null_roll, rate_null_pitch, rate_null_yaw;
  logic [ADC_BITS-1:0] temp_null_roll, temp_null_pitch, temp_null_yaw;
  logic [VPC_W-1:0]    volts_per_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_null_roll  <= RST_RATE_NULL_ROLL;
      rate_null_pitch <= RST_RATE_NULL_PITCH;
      rate_null_yaw   <= RST_RATE_NULL_YAW;
      temp_null_roll  <= RST_TEMP_NULL;
      temp_null_pitch <= RST_TEMP_NULL;
      temp_null_yaw   <= RST_TEMP_NULL;
      volts_per_count <= RST_VOLTS_PER_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_NULL_ROLL:  rate_null_roll  <= cfg_data[ADC_BITS-1:0];
        REG_RATE_NULL_PITCH: rate_null_pitch <= cfg_data[ADC_BITS-1:0];
        REG_RATE_NULL_YAW:   rate_null_yaw   <= cfg_data[ADC_BITS-1:0];
        REG_TEMP_NULL_ROLL:  temp_null_roll  <= cfg_data[ADC_BITS-1:0];
        REG_TEMP_NULL_PITCH: temp_null_pitch <= cfg_data[ADC_BITS-1:0];
        REG_TEMP_NULL_YAW:   temp_null_yaw   <= cfg_data[ADC_BITS-1:0];
        REG_VOLTS_PER_COUNT: volts_per_count <= cfg_data[VPC_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // input stage
  tag_t                s0_tag;
  logic [ADC_BITS-1:0] s0_rate, s0_ref, s0_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_tag <= '0;
    end else begin
      s0_tag <= '{vld: start & ~busy, axis: sample.axis,
                  inv: (sample.ref_count == '0), neg: 1'b0, ovf: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    s0_rate <= sample.rate_count;
    s0_ref  <= sample.ref_count;
    s0_temp <= sample.temp_count;
  end

  // rescale by 2^(adc_bits-1) / ref in Q.12
  logic [Q_W-1:0] q_rate, q_temp;

  grtc_udiv #(.LW(Q_W), .DW(ADC_BITS)) u_div_rate (
    .clk      (clk),
    .rem_init ('0),
    .dividend ({s0_rate, {DIV_SHIFT{1'b0}}}),
    .den      (s0_ref),
    .quot     (q_rate)
  );

  grtc_udiv #(.LW(Q_W), .DW(ADC_BITS)) u_div_temp (
    .clk      (clk),
    .rem_init ('0),
    .dividend ({s0_temp, {DIV_SHIFT{1'b0}}}),
    .den      (s0_ref),
    .quot     (q_temp)
  );

  tag_t tag_a [0:Q_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_W; i++) begin
        tag_a[i] <= '0;
      end
    end else begin
      tag_a[0] <= s0_tag;
      for (int i = 1; i < Q_W; i++) begin
        tag_a[i] <= tag_a[i-1];
      end
    end
  end

  // null select, axis three falls to yaw
  logic [ADC_BITS-1:0] rnull_sel, tnull_sel;

  always_comb begin
    case (tag_a[Q_W-1].axis)
      AXIS_ROLL: begin
        rnull_sel = rate_null_roll;
        tnull_sel = temp_null_roll;
      end
      AXIS_PITCH: begin
        rnull_sel = rate_null_pitch;
        tnull_sel = temp_null_pitch;
      end
      default: begin
        rnull_sel = rate_null_yaw;
        tnull_sel = temp_null_yaw;
      end
    endcase
  end

  // count difference from the null
  tag_t                     s1_tag, s2_tag, s3_tag;
  logic signed [DIFF_W-1:0] s1_diff_rate, s1_diff_temp;
  logic signed [PROD_W-1:0] s2_prod_rate, s2_prod_temp;
  logic signed [DV_W-1:0]   s3_d_rate, s3_d_temp;

  always_ff @(posedge clk) begin
    s1_diff_rate <= $signed({1'b0, q_rate})
                  - $signed({{(DIFF_W-ADC_BITS-CNT_FRAC){1'b0}}, rnull_sel,
                             {CNT_FRAC{1'b0}}});
    s1_diff_temp <= $signed({1'b0, q_temp})
                  - $signed({{(DIFF_W-ADC_BITS-CNT_FRAC){1'b0}}, tnull_sel,
                             {CNT_FRAC{1'b0}}});
  end

  // to volts, Q.36
  always_ff @(posedge clk) begin
    s2_prod_rate <= s1_diff_rate * $signed({1'b0, volts_per_count});
    s2_prod_temp <= s1_diff_temp * $signed({1'b0, volts_per_count});
  end

  // floor to Q.20 and clamp to plus or minus (2^31 - 1)
  function automatic logic signed [DV_W-1:0] clamp_volts(
    input logic signed [SH_W-1:0] v
  );
    logic signed [SH_W-1:0] c;
    c = v;
    if (v > V_HI) c = V_HI;
    if (v < V_LO) c = V_LO;
    return c[DV_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    s3_d_rate <= clamp_volts(s2_prod_rate[PROD_W-1:VOLT_SHIFT]);
    s3_d_temp <= clamp_volts(s2_prod_temp[PROD_W-1:VOLT_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s1_tag <= tag_a[Q_W-1];
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
  end

  // temperature polynomials
  logic signed [COMP_W-1:0] p_comp;
  logic [SCALE_W-1:0]       p_scale;

  grtc_poly u_poly (
    .clk    (clk),
    .d_rate (s3_d_rate),
    .d_temp (s3_d_temp),
    .comp   (p_comp),
    .scale  (p_scale)
  );

  tag_t tag_p [0:POLY_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POLY_LAT; i++) begin
        tag_p[i] <= '0;
      end
    end else begin
      tag_p[0] <= s3_tag;
      for (int i = 1; i < POLY_LAT; i++) begin
        tag_p[i] <= tag_p[i-1];
      end
    end
  end

  // magnitude times the rad/s factor, as two partial products
  logic [MAG_W-1:0]   mag;
  logic               comp_neg;
  tag_t               s4_tag, s5_tag, s4_tag_next;
  logic [40:0]        s4_phi, s4_plo;
  logic [SCALE_W-1:0] s4_scale, s5_scale;
  logic [N_W-1:0]     s5_n;

  assign comp_neg = p_comp < 0;
  assign mag      = comp_neg ? MAG_W'(-p_comp) : MAG_W'(p_comp);

  always_ff @(posedge clk) begin
    s4_phi   <= RAD_K * mag[MAG_W-1:VOLT_FRAC];
    s4_plo   <= RAD_K * mag[VOLT_FRAC-1:0];
    s4_scale <= p_scale;
  end

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    s5_n     <= N_W'({s4_phi, {VOLT_FRAC{1'b0}}}) + N_W'(s4_plo)
              + N_W'(s4_scale[SCALE_W-1:1]);
    s5_scale <= s4_scale;
  end

  // sign of the corrected rate joins the tag
  always_comb begin
    s4_tag_next     = tag_p[POLY_LAT-1];
    s4_tag_next.neg = comp_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag <= '0;
      s5_tag <= '0;
    end else begin
      s4_tag <= s4_tag_next;
      s5_tag <= s4_tag;
    end
  end

  // final division, quotient of 2^32 or more saturates
  tag_t           div_tag;
  logic [QF_W-1:0] q_final;

  always_comb begin
    div_tag     = s5_tag;
    div_tag.ovf = SCALE_W'(s5_n[N_W-1:QF_W]) >= s5_scale;
  end

  grtc_udiv #(.LW(QF_W), .DW(SCALE_W)) u_div_final (
    .clk      (clk),
    .rem_init (SCALE_W'(s5_n[N_W-1:QF_W])),
    .dividend (s5_n[QF_W-1:0]),
    .den      (s5_scale),
    .quot     (q_final)
  );

  tag_t tag_b [0:QF_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QF_W; i++) begin
        tag_b[i] <= '0;
      end
    end else begin
      tag_b[0] <= div_tag;
      for (int i = 1; i < QF_W; i++) begin
        tag_b[i] <= tag_b[i-1];
      end
    end
  end

  // sign, saturation and output word
  tag_t               out_tag;
  logic signed [31:0] rate_sat;

  assign out_tag = tag_b[QF_W-1];

  always_comb begin
    if (out_tag.inv) begin
      rate_sat = '0;
    end else if (out_tag.neg) begin
      if (out_tag.ovf || q_final > 32'h8000_0000) begin
        rate_sat = 32'sh8000_0000;
      end else begin
        rate_sat = -$signed(q_final);
      end
    end else begin
      if (out_tag.ovf || q_final[QF_W-1]) begin
        rate_sat = 32'sh7FFF_FFFF;
      end else begin
        rate_sat = $signed(q_final);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= '{axis_out: out_tag.axis, rate_rad_per_s: rate_sat,
                invalid: out_tag.inv};
  end

  // every accepted sample comes out a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY result_valid)
    else $error("sample accepted without a result at the expected latency");

  // no result without a sample taken that long ago
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching sample");

  // a zero reference gives a zero rate
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.invalid) |-> (result.rate_rad_per_s == 0))
    else $error("invalid result with nonzero rate");

endmodule
`default_nettype wire
